// File: sv/twn_pkg.sv
// ----------------------------------------------------------------------------
// twn_pkg
// Shared types and constants of the text whitespace normalizer.
// ----------------------------------------------------------------------------
`default_nettype none

package twn_pkg;

  // Character codes
  localparam logic [15:0] CH_TAB = 16'h0009;
  localparam logic [15:0] CH_LF  = 16'h000A;
  localparam logic [15:0] CH_CR  = 16'h000D;
  localparam logic [15:0] CH_SP  = 16'h0020;

  // Configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_NORM_LE   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIM      = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TAB_STOP  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BLANK = 4'd3;

  // Clamp limits of the 5-bit registers
  localparam logic [4:0] TAB_MAX   = 5'd16;
  localparam logic [4:0] BLANK_MAX = 5'd20;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        is_last;
  } in_t;

  typedef struct packed {
    logic [15:0] out_unit;
    logic        unit_valid;
    logic        last_in_run;
    logic        text_end;
    logic        pending_overflow;
  } out_t;

  // Unicode space set of the usual string class (isSpace)
  function automatic logic is_space(input logic [15:0] u);
    logic r;
    if (u <= 16'h00FF) begin
      r = (u == CH_SP) || (u >= 16'h0009 && u <= 16'h000D) ||
          (u == 16'h0085) || (u == 16'h00A0);
    end else begin
      r = (u == 16'h1680) || (u >= 16'h2000 && u <= 16'h200A) ||
          (u == 16'h2028) || (u == 16'h2029) || (u == 16'h202F) ||
          (u == 16'h205F) || (u == 16'h3000);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: sv/text_whitespace_normalizer.sv
// ----------------------------------------------------------------------------
// text_whitespace_normalizer
// Line-end, tab, trailing-space and blank-line cleanup of a UTF-16 stream.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one code unit per transfer; is_last closes the text and the
//            block then returns to its start-of-text state.
//   out_*  : the resulting code units; last_in_run marks the final result
//            of one input transfer, text_end the final result of a text.
//            A text that yields nothing still gets one marker result
//            (unit_valid low) with text_end set.
//   cfg_*  : register writes, always ready; write only while the block is
//            idle.
// Timing: one item at a time. A unit that passes straight through goes
//   through accept, dispatch, emit and close-out before the next
//   transfer; each further result takes a step of its own, a flush of the
//   pending whitespace memory first waits for its registered read, and after
//   a tab width change the column is reduced one subtract per cycle. The
//   sequencer and the single read port of the pending memory set this pace.
//   The first result passes the look-ahead slot and the output register.
// Reset (rst_n low, synchronous): registers return to their defaults, the
//   sticky overflow flag clears, nothing is output.
// Stalls: a stalled output holds; the sequencer keeps one result in a
//   look-ahead slot and waits when both slots are full. in_stall is high
//   whenever an item is in progress.
// ----------------------------------------------------------------------------
`default_nettype none

module text_whitespace_normalizer
  import twn_pkg::*;
#(
  parameter int PENDING_DEPTH = 48
) (
  input  wire                   clk,
  input  wire                   rst_n,
  // input channel
  input  wire                   in_valid,
  output logic                  in_stall,
  input  in_t                   in_data,
  // result channel
  output logic                  out_valid,
  input  wire                   out_stall,
  output out_t                  out_data,
  // configuration write channel
  input  wire                   cfg_valid,
  output logic                  cfg_ready,
  input  wire [CFG_IDX_W-1:0]   cfg_index,
  input  wire [CFG_DATA_W-1:0]  cfg_wdata
);

  // count holds 0..PENDING_DEPTH, address 0..PENDING_DEPTH-1
  localparam int CW = $clog2(PENDING_DEPTH + 1);
  localparam int AW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(PENDING_DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_DISP  = 7'b0000010,
    ST_PUTU  = 7'b0000100,
    ST_TAB   = 7'b0001000,
    ST_CLOSE = 7'b0010000,
    ST_FLUSH = 7'b0100000,
    ST_END   = 7'b1000000
  } state_t;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic       norm_le_r;
  logic       trim_r;
  logic [4:0] tab_w_r;
  logic [4:0] max_blank_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      norm_le_r   <= 1'b1;
      trim_r      <= 1'b0;
      tab_w_r     <= 5'd4;
      max_blank_r <= 5'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_NORM_LE:   norm_le_r   <= cfg_wdata[0];
        CFG_TRIM:      trim_r      <= cfg_wdata[0];
        CFG_TAB_STOP:  tab_w_r     <= cfg_wdata[4:0];
        CFG_MAX_BLANK: max_blank_r <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  logic [4:0] tw_eff;
  logic [4:0] mb_eff;
  assign tw_eff = (tab_w_r > TAB_MAX) ? TAB_MAX : tab_w_r;
  assign mb_eff = (max_blank_r > BLANK_MAX) ? BLANK_MAX : max_blank_r;

  // --------------------------------------------------------------------------
  // Pending whitespace memory: one write port, one registered read port
  // --------------------------------------------------------------------------
  logic [15:0]   pend_mem [PENDING_DEPTH];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [15:0]   mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [15:0]   mem_rdata_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      pend_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_r <= pend_mem[mem_raddr];
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer state
  // --------------------------------------------------------------------------
  state_t        state_r,     state_nxt;
  logic [15:0]   unit_r,      unit_nxt;
  logic          last_r,      last_nxt;
  logic          fin_r,       fin_nxt;     // final close of the text started
  logic [CW-1:0] count_r,     count_nxt;   // pending entries
  logic [CW-1:0] keep_r,      keep_nxt;    // entries kept when trimming
  logic          blank_r,     blank_nxt;   // line is blank so far
  logic          first_r,     first_nxt;   // still on the first line
  logic          after_cr_r,  after_cr_nxt;
  logic [4:0]    brun_r,      brun_nxt;    // blank line run
  logic [3:0]    col_r,       col_nxt;     // column modulo tab width
  logic          ovf_r,       ovf_nxt;     // sticky overflow
  logic [4:0]    tab_n_r,     tab_n_nxt;   // spaces left of a tab
  logic [CW-1:0] flim_r,      flim_nxt;    // flush length
  logic [CW-1:0] fidx_r,      fidx_nxt;    // flush position
  logic          rd_ok_r,     rd_ok_nxt;   // read data holds entry fidx
  logic          f2put_r,     f2put_nxt;   // flush is followed by the unit
  logic          cand_v_r,    cand_v_nxt;  // look-ahead result slot
  logic [15:0]   cand_unit_r, cand_unit_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_t          out_data_r,  out_data_nxt;

  // working signals
  logic          out_free;
  logic          adv;
  logic          gen_v;
  logic [15:0]   gen_unit;
  logic          hold_en;
  logic [15:0]   hold_unit;
  logic          out_load;
  logic          need_red;
  logic [3:0]    col_adv;
  logic          swallow;
  logic          line_end;
  logic [4:0]    brun_inc;
  logic          keep_line;
  logic [CW-1:0] close_lim;
  logic [CW-1:0] fidx_inc;

  assign out_free = !out_valid_r || !out_stall;
  // a new result can be taken when the look-ahead slot is empty or can spill
  assign adv      = !cand_v_r || out_free;
  assign fidx_inc = fidx_r + ONE_C;

  assign need_red = (tw_eff != 5'd0) && ({1'b0, col_r} >= tw_eff);
  // column after one printed unit; col_r is already below tw_eff here
  assign col_adv  = (tw_eff == 5'd0) ? 4'd0 :
                    (({1'b0, col_r} + 5'd1) == tw_eff) ? 4'd0 : (col_r + 4'd1);

  assign swallow  = norm_le_r && after_cr_r && (unit_r == CH_LF);
  assign line_end = (unit_r == CH_LF) || (norm_le_r && (unit_r == CH_CR));

  assign brun_inc  = (brun_r <= mb_eff) ? (brun_r + 5'd1) : brun_r;
  assign keep_line = !(blank_r && (mb_eff != 5'd0) && (brun_inc > mb_eff));
  assign close_lim = trim_r ? keep_r : count_r;

  always_comb begin
    state_nxt     = state_r;
    unit_nxt      = unit_r;
    last_nxt      = last_r;
    fin_nxt       = fin_r;
    count_nxt     = count_r;
    keep_nxt      = keep_r;
    blank_nxt     = blank_r;
    first_nxt     = first_r;
    after_cr_nxt  = after_cr_r;
    brun_nxt      = brun_r;
    col_nxt       = col_r;
    ovf_nxt       = ovf_r;
    tab_n_nxt     = tab_n_r;
    flim_nxt      = flim_r;
    fidx_nxt      = fidx_r;
    rd_ok_nxt     = rd_ok_r;
    f2put_nxt     = f2put_r;
    cand_v_nxt    = cand_v_r;
    cand_unit_nxt = cand_unit_r;
    out_data_nxt  = out_data_r;
    out_load      = 1'b0;
    gen_v         = 1'b0;
    gen_unit      = CH_LF;
    hold_en       = 1'b0;
    hold_unit     = CH_SP;
    mem_we        = 1'b0;
    mem_waddr     = count_r[AW-1:0];
    mem_wdata     = hold_unit;
    mem_re        = 1'b0;
    mem_raddr     = fidx_r[AW-1:0];

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          unit_nxt  = in_data.code_unit;
          last_nxt  = in_data.is_last;
          state_nxt = ST_DISP;
        end
      end

      ST_DISP: begin
        if (need_red) begin
          // bring the column below a freshly written tab width
          col_nxt = col_r - tw_eff[3:0];
        end else if (adv) begin
          if (swallow) begin
            after_cr_nxt = 1'b0;
            state_nxt    = ST_END;
          end else begin
            after_cr_nxt = norm_le_r && (unit_r == CH_CR);
            if (line_end) begin
              state_nxt = ST_CLOSE;
            end else if (is_space(unit_r)) begin
              if ((unit_r == CH_TAB) && (tw_eff != 5'd0)) begin
                tab_n_nxt = tw_eff - {1'b0, col_r};
                col_nxt   = 4'd0;
                state_nxt = ST_TAB;
              end else begin
                hold_en   = 1'b1;
                hold_unit = unit_r;
                col_nxt   = col_adv;
                state_nxt = ST_END;
              end
            end else begin
              // printable unit: separator, pending whitespace, unit
              if (blank_r) begin
                if (mb_eff != 5'd0) begin
                  brun_nxt = 5'd0;
                end
                if (!first_r) begin
                  gen_v    = 1'b1;
                  gen_unit = CH_LF;
                end
                blank_nxt = 1'b0;
              end
              flim_nxt  = count_r;
              count_nxt = '0;
              keep_nxt  = '0;
              f2put_nxt = 1'b1;
              state_nxt = (count_r == '0) ? ST_PUTU : ST_FLUSH;
            end
          end
        end
      end

      ST_PUTU: begin
        if (adv) begin
          gen_v     = 1'b1;
          gen_unit  = unit_r;
          col_nxt   = col_adv;
          state_nxt = ST_END;
        end
      end

      ST_TAB: begin
        if (adv) begin
          hold_en   = 1'b1;
          hold_unit = CH_SP;
          tab_n_nxt = tab_n_r - 5'd1;
          if (tab_n_r == 5'd1) begin
            state_nxt = ST_END;
          end
        end
      end

      ST_CLOSE: begin
        if (adv) begin
          if (blank_r && (mb_eff != 5'd0)) begin
            brun_nxt = brun_inc;
          end
          if (blank_r && keep_line && !first_r) begin
            gen_v    = 1'b1;
            gen_unit = CH_LF;
          end
          flim_nxt  = close_lim;
          f2put_nxt = 1'b0;
          count_nxt = '0;
          keep_nxt  = '0;
          blank_nxt = 1'b1;
          first_nxt = 1'b0;
          col_nxt   = 4'd0;
          state_nxt = (keep_line && (close_lim != '0)) ? ST_FLUSH : ST_END;
        end
      end

      ST_FLUSH: begin
        if (!rd_ok_r) begin
          mem_re    = 1'b1;
          mem_raddr = fidx_r[AW-1:0];
          rd_ok_nxt = 1'b1;
        end else if (adv) begin
          gen_v    = 1'b1;
          gen_unit = mem_rdata_r;
          if (fidx_inc < flim_r) begin
            mem_re    = 1'b1;
            mem_raddr = fidx_inc[AW-1:0];
            fidx_nxt  = fidx_inc;
          end else begin
            fidx_nxt  = '0;
            rd_ok_nxt = 1'b0;
            state_nxt = f2put_r ? ST_PUTU : ST_END;
          end
        end
      end

      ST_END: begin
        if (last_r && !fin_r) begin
          fin_nxt   = 1'b1;
          state_nxt = ST_CLOSE;
        end else if (!cand_v_r && !last_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_load                      = 1'b1;
          out_data_nxt.out_unit         = cand_v_r ? cand_unit_r : 16'h0000;
          out_data_nxt.unit_valid       = cand_v_r;
          out_data_nxt.last_in_run      = 1'b1;
          out_data_nxt.text_end         = last_r;
          out_data_nxt.pending_overflow = ovf_r;
          cand_v_nxt                    = 1'b0;
          if (last_r) begin
            count_nxt    = '0;
            keep_nxt     = '0;
            blank_nxt    = 1'b1;
            first_nxt    = 1'b1;
            after_cr_nxt = 1'b0;
            brun_nxt     = 5'd0;
            col_nxt      = 4'd0;
            fin_nxt      = 1'b0;
          end
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase

    // whitespace goes out at once on a text line with trim off and nothing held, else into the memory
    mem_wdata = hold_unit;
    if (hold_en) begin
      if (!blank_r && !trim_r && (count_r == '0)) begin
        gen_v    = 1'b1;
        gen_unit = hold_unit;
      end else if (count_r < DEPTH_C) begin
        mem_we    = 1'b1;
        count_nxt = count_r + ONE_C;
        if ((hold_unit != CH_SP) && (hold_unit != CH_TAB)) begin
          keep_nxt = count_r + ONE_C;
        end
      end else begin
        ovf_nxt = 1'b1;
      end
    end

    // new result: the slot spills to the output, the new one takes the slot
    if (gen_v) begin
      if (cand_v_r) begin
        out_load                      = 1'b1;
        out_data_nxt.out_unit         = cand_unit_r;
        out_data_nxt.unit_valid       = 1'b1;
        out_data_nxt.last_in_run      = 1'b0;
        out_data_nxt.text_end         = 1'b0;
        out_data_nxt.pending_overflow = ovf_r;
      end
      cand_v_nxt    = 1'b1;
      cand_unit_nxt = gen_unit;
    end

    out_valid_nxt = out_load ? 1'b1 : (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      last_r      <= 1'b0;
      fin_r       <= 1'b0;
      count_r     <= '0;
      keep_r      <= '0;
      blank_r     <= 1'b1;
      first_r     <= 1'b1;
      after_cr_r  <= 1'b0;
      brun_r      <= 5'd0;
      col_r       <= 4'd0;
      ovf_r       <= 1'b0;
      tab_n_r     <= 5'd0;
      flim_r      <= '0;
      fidx_r      <= '0;
      rd_ok_r     <= 1'b0;
      f2put_r     <= 1'b0;
      cand_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      last_r      <= last_nxt;
      fin_r       <= fin_nxt;
      count_r     <= count_nxt;
      keep_r      <= keep_nxt;
      blank_r     <= blank_nxt;
      first_r     <= first_nxt;
      after_cr_r  <= after_cr_nxt;
      brun_r      <= brun_nxt;
      col_r       <= col_nxt;
      ovf_r       <= ovf_nxt;
      tab_n_r     <= tab_n_nxt;
      flim_r      <= flim_nxt;
      fidx_r      <= fidx_nxt;
      rd_ok_r     <= rd_ok_nxt;
      f2put_r     <= f2put_nxt;
      cand_v_r    <= cand_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    unit_r      <= unit_nxt;
    cand_unit_r <= cand_unit_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// File: sv/twn_checker.sv
// ----------------------------------------------------------------------------
// twn_checker
// Port-level checks of the text whitespace normalizer, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module twn_checker
  import twn_pkg::*;
(
  input wire  clk,
  input wire  rst_n,
  input wire  in_valid,
  input wire  in_stall,
  input in_t  in_data,
  input wire  out_valid,
  input wire  out_stall,
  input out_t out_data
);

  // overflow seen on an earlier transfer
  logic ovf_seen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovf_seen_r <= 1'b0;
    end else if (out_valid && !out_stall && out_data.pending_overflow) begin
      ovf_seen_r <= 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ovf_seen_r |-> out_data.pending_overflow)
    else $error("overflow flag dropped");

  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.text_end |-> out_data.last_in_run)
    else $error("text end without last_in_run");

  a_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.unit_valid |->
      out_data.text_end && out_data.last_in_run && (out_data.out_unit == 16'h0000))
    else $error("malformed marker");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while busy");

endmodule

bind text_whitespace_normalizer twn_checker u_twn_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

// File: tb/sv/text_whitespace_normalizer_tb.sv
// ----------------------------------------------------------------------------
// text_whitespace_normalizer_tb
// Self-checking bench: streams UTF-16 texts through the normalizer under
// several register settings and idle patterns, predicts every result
// transfer in the bench and compares each one field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module text_whitespace_normalizer_tb;
  import twn_pkg::*;

  localparam int PEND_DEPTH    = 48;      // must match the DUT parameter
  localparam int MAX_PER_ITEM  = 64;      // cap on results per input transfer
  localparam int SETTLE_CYCLES = 100;     // quiet time before a register write
  localparam int HOLD_CYCLES   = 400;     // long receiver hold-off
  localparam int CYCLE_LIMIT   = 300000;  // timeout
  localparam int SHOW_LIMIT    = 10;      // mismatches printed in full

  // index that decodes to no register; writes to it must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 4'd9;

  // --------------------------------------------------------------------------
  // DUT signals
  // --------------------------------------------------------------------------
  logic                  clk;
  logic                  rst_n;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_t                   in_data  = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_t                  out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  text_whitespace_normalizer #(
    .PENDING_DEPTH (PEND_DEPTH)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  in_t  unit_q[$];        // code units waiting to be driven
  out_t expect_q[$];      // predicted results, oldest first
  out_t step_q[$];        // results of the unit being predicted

  int   n_queued   = 0;   // units pushed by the stimulus
  int   n_accepted = 0;   // units taken by the DUT
  int   fail_cnt   = 0;
  int   cycles     = 0;
  int   gap_pct    = 0;   // sender idle chance, percent
  int   stall_pct  = 0;   // receiver stall chance, percent
  int   hold_req   = 0;   // bumped by the stimulus to ask for a long hold-off
  int   hold_seen  = 0;   // owned by the stall process
  int   hold_left  = 0;   // owned by the stall process
  logic in_took    = 1'b0; // input transfer at the last rising edge
  logic cfg_took   = 1'b0; // register write at the last rising edge

  // --------------------------------------------------------------------------
  // Predictor state: register shadows and the per-text line state
  // --------------------------------------------------------------------------
  logic        norm_le;
  logic        trim_on;
  logic [4:0]  tab_reg;
  logic [4:0]  blank_reg;

  logic [15:0] pend [PEND_DEPTH];   // held whitespace of the current line
  int          pend_cnt;
  int          keep_cnt;            // held entries that survive trimming
  logic        line_blank;          // nothing but whitespace so far
  logic        first_line;          // no line end seen in this text yet
  logic        after_cr;            // last unit was a line-ending CR
  int          blank_run;
  int          tab_col;             // column modulo tab width
  logic        ovf_q;               // sticky pending overflow

  // registers above their range act as the top of the range
  function automatic int eff_tab_w();
    return (tab_reg > TAB_MAX) ? int'(TAB_MAX) : int'(tab_reg);
  endfunction

  function automatic int eff_blank_max();
    return (blank_reg > BLANK_MAX) ? int'(BLANK_MAX) : int'(blank_reg);
  endfunction

  task automatic put_res(input logic [15:0] u, input logic v);
    out_t r;
    r            = '0;
    r.out_unit   = u;
    r.unit_valid = v;
    if (step_q.size() < MAX_PER_ITEM) step_q.push_back(r);
  endtask

  task automatic step_column();
    int tw;
    tw = eff_tab_w();
    tab_col = (tw == 0) ? 0 : ((tab_col % tw) + 1) % tw;
  endtask

  // Whitespace goes straight out only on a line that already has text,
  // with trimming off and nothing held; otherwise it waits.
  task automatic hold_space(input logic [15:0] u);
    if (!line_blank && !trim_on && pend_cnt == 0) begin
      put_res(u, 1'b1);
    end else if (pend_cnt < PEND_DEPTH) begin
      pend[pend_cnt] = u;
      pend_cnt++;
      if (u != CH_SP && u != CH_TAB) keep_cnt = pend_cnt;
    end else begin
      ovf_q = 1'b1;
    end
  endtask

  task automatic flush_pend(input int lim);
    for (int i = 0; i < lim && i < PEND_DEPTH; i++) put_res(pend[i], 1'b1);
    pend_cnt = 0;
    keep_cnt = 0;
  endtask

  // End of a line: a blank line may be dropped once the run is too long;
  // a kept blank line brings its LF separator, then the held whitespace.
  task automatic close_cur_line();
    logic keep;
    int   mb;
    keep = 1'b1;
    if (line_blank) begin
      mb = eff_blank_max();
      if (mb > 0) begin
        if (blank_run <= mb) blank_run++;
        if (blank_run > mb) keep = 1'b0;
      end
      if (keep && !first_line) put_res(CH_LF, 1'b1);
    end
    if (keep) flush_pend(trim_on ? keep_cnt : pend_cnt);
    pend_cnt   = 0;
    keep_cnt   = 0;
    line_blank = 1'b1;
    first_line = 1'b0;
    tab_col    = 0;
  endtask

  task automatic clear_text();
    pend_cnt   = 0;
    keep_cnt   = 0;
    line_blank = 1'b1;
    first_line = 1'b1;
    after_cr   = 1'b0;
    blank_run  = 0;
    tab_col    = 0;
  endtask

  // --------------------------------------------------------------------------
  // Driver: presents queued units at the falling edge. A unit stays on the
  // bus until a transfer is seen; the next one can follow without a dip.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (unit_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
        in_valid <= 1'b1;
        in_data  <= unit_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall: random, or a long solid hold-off when one is requested.
  // While held, the sender keeps offering, so the DUT backs up to its input.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: at the rising edge, mirror register writes, predict the results
  // of every input transfer and check every result transfer.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : mon
    logic [15:0] u;
    logic        is_ws;
    int          tw;
    int          n;
    out_t        want;
    if (!rst_n) begin
      norm_le   = 1'b1;
      trim_on   = 1'b0;
      tab_reg   = 5'd4;
      blank_reg = 5'd0;
      ovf_q     = 1'b0;
      clear_text();
      in_took  <= 1'b0;
      cfg_took <= 1'b0;
    end else begin
      in_took  <= in_valid && !in_stall;
      cfg_took <= cfg_valid && cfg_ready;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_NORM_LE:   norm_le   = cfg_wdata[0];
          CFG_TRIM:      trim_on   = cfg_wdata[0];
          CFG_TAB_STOP:  tab_reg   = cfg_wdata[4:0];
          CFG_MAX_BLANK: blank_reg = cfg_wdata[4:0];
          default: ;
        endcase
      end

      if (in_valid && !in_stall) begin
        n_accepted <= n_accepted + 1;
        u = in_data.code_unit;
        // isSpace set: C0 TAB..CR, SP, NEL, NBSP and the wide spaces
        if (u <= 16'h00FF)
          is_ws = (u == CH_SP) || (u >= CH_TAB && u <= CH_CR) ||
                  (u == 16'h0085) || (u == 16'h00A0);
        else
          is_ws = (u == 16'h1680) || (u >= 16'h2000 && u <= 16'h200A) ||
                  (u == 16'h2028) || (u == 16'h2029) || (u == 16'h202F) ||
                  (u == 16'h205F) || (u == 16'h3000);

        if (norm_le && after_cr && u == CH_LF) begin
          // LF of a CRLF pair: the CR already ended the line
          after_cr = 1'b0;
        end else begin
          after_cr = norm_le && (u == CH_CR);
          if (u == CH_LF || (u == CH_CR && norm_le)) begin
            close_cur_line();
          end else if (is_ws) begin
            tw = eff_tab_w();
            if (u == CH_TAB && tw > 0) begin
              // tab becomes spaces up to the next stop
              n = tw - (tab_col % tw);
              repeat (n) hold_space(CH_SP);
              tab_col = 0;
            end else begin
              hold_space(u);
              step_column();
            end
          end else begin
            // first text on a line: separator, then held whitespace
            if (line_blank) begin
              if (eff_blank_max() > 0) blank_run = 0;
              if (!first_line) put_res(CH_LF, 1'b1);
              line_blank = 1'b0;
            end
            flush_pend(pend_cnt);
            put_res(u, 1'b1);
            step_column();
          end
        end

        if (in_data.is_last) begin
          close_cur_line();
          if (step_q.size() == 0) put_res(16'h0000, 1'b0);  // bare end marker
          clear_text();
        end

        foreach (step_q[k]) begin
          step_q[k].pending_overflow = ovf_q;
          step_q[k].last_in_run      = (k == step_q.size() - 1);
          step_q[k].text_end         = in_data.is_last && (k == step_q.size() - 1);
          expect_q.push_back(step_q[k]);
        end
        step_q.delete();
      end

      if (out_valid && !out_stall) begin
        if (expect_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= SHOW_LIMIT)
            $display("unexpected result: unit=%h v=%b lr=%b end=%b ovf=%b",
                     out_data.out_unit, out_data.unit_valid, out_data.last_in_run,
                     out_data.text_end, out_data.pending_overflow);
        end else begin
          want = expect_q.pop_front();
          if (out_data.out_unit         !== want.out_unit    ||
              out_data.unit_valid       !== want.unit_valid  ||
              out_data.last_in_run      !== want.last_in_run ||
              out_data.text_end         !== want.text_end    ||
              out_data.pending_overflow !== want.pending_overflow) begin
            fail_cnt++;
            if (fail_cnt <= SHOW_LIMIT) begin
              $write("result mismatch: exp unit=%h v=%b lr=%b end=%b ovf=%b, ",
                     want.out_unit, want.unit_valid, want.last_in_run,
                     want.text_end, want.pending_overflow);
              $display("got unit=%h v=%b lr=%b end=%b ovf=%b",
                       out_data.out_unit, out_data.unit_valid, out_data.last_in_run,
                       out_data.text_end, out_data.pending_overflow);
            end
          end
        end
      end
    end
  end

  // timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic push_unit(input logic [15:0] u, input logic is_end);
    in_t it;
    it.code_unit = u;
    it.is_last   = is_end;
    unit_q.push_back(it);
    n_queued++;
  endtask

  // Everything taken and every result back, then a quiet stretch so a unit
  // that makes no result (held whitespace, swallowed LF) has finished too.
  // Checked at the falling edge, where all bench counters are stable.
  task automatic wait_idle();
    @(negedge clk);
    while (n_accepted != n_queued || expect_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(negedge clk); while (!cfg_took);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_regs(input logic [CFG_DATA_W-1:0] norm,
                          input logic [CFG_DATA_W-1:0] trim,
                          input logic [CFG_DATA_W-1:0] tabw,
                          input logic [CFG_DATA_W-1:0] blank);
    write_reg(CFG_NORM_LE, norm);
    write_reg(CFG_TRIM, trim);
    write_reg(CFG_TAB_STOP, tabw);
    write_reg(CFG_MAX_BLANK, blank);
  endtask

  // queue filling happens at the rising edge so the driver never races it
  task automatic start_phase(input int gap, input int stall);
    @(posedge clk);
    gap_pct   = gap;
    stall_pct = stall;
  endtask

  // Random texts: mostly well-formed lines (words, spaces, tabs, line ends,
  // runs of blank lines) with some arbitrary 16-bit units mixed in.
  task automatic fill_random(input int target);
    logic [15:0] units[$];
    logic [15:0] u;
    int          base;
    int          len;
    int          sel;
    base = n_queued;
    while (n_queued - base < target) begin
      len = $urandom_range(12, 1);
      units.delete();
      while (units.size() < len) begin
        sel = $urandom_range(99);
        if (sel < 28) begin
          units.push_back(16'($urandom_range(16'h7E, 16'h21)));
        end else if (sel < 36) begin
          units.push_back(16'($urandom_range(16'hFFFF, 0)));
        end else if (sel < 42) begin
          // non-space neighbors of the space set
          case ($urandom_range(9))
            0:       u = 16'h0008;
            1:       u = 16'h000E;
            2:       u = 16'h0084;
            3:       u = 16'h0086;
            4:       u = 16'h00A1;
            5:       u = 16'h1681;
            6:       u = 16'h1FFF;
            7:       u = 16'h200B;
            8:       u = 16'h205E;
            default: u = 16'h3001;
          endcase
          units.push_back(u);
        end else if (sel < 55) begin
          units.push_back(CH_SP);
        end else if (sel < 63) begin
          units.push_back(CH_TAB);
        end else if (sel < 68) begin
          // other whitespace, kept through trimming
          case ($urandom_range(12))
            0:       u = 16'h000B;
            1:       u = 16'h000C;
            2:       u = 16'h0085;
            3:       u = 16'h00A0;
            4:       u = 16'h1680;
            5:       u = 16'h2000;
            6:       u = 16'h2006;
            7:       u = 16'h200A;
            8:       u = 16'h2028;
            9:       u = 16'h2029;
            10:      u = 16'h202F;
            11:      u = 16'h205F;
            default: u = 16'h3000;
          endcase
          units.push_back(u);
        end else if (sel < 75) begin
          units.push_back(CH_LF);
        end else if (sel < 81) begin
          units.push_back(CH_CR);
        end else if (sel < 88) begin
          units.push_back(CH_CR);
          units.push_back(CH_LF);
        end else begin
          // run of blank lines, some with a space in them
          repeat ($urandom_range(6, 2)) begin
            if ($urandom_range(1) == 1) units.push_back(CH_SP);
            units.push_back(CH_LF);
          end
        end
      end
      foreach (units[k]) push_unit(units[k], k == units.size() - 1);
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n     = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // Directed, reset registers (CR folding on, no trim, tab 4, keep all).
    start_phase(0, 0);
    push_unit(16'h0000, 1'b0);    // lowest code unit, plain text
    push_unit(CH_TAB, 1'b0);
    push_unit(16'h3000, 1'b0);
    push_unit(CH_CR, 1'b0);       // CRLF pair
    push_unit(CH_LF, 1'b0);
    push_unit(CH_CR, 1'b0);       // lone CR: empty line
    push_unit(16'hFFFF, 1'b0);    // highest code unit
    push_unit(CH_SP, 1'b0);
    push_unit(CH_LF, 1'b0);
    push_unit(16'h0085, 1'b0);
    push_unit(CH_SP, 1'b1);       // text closes on a blank line
    push_unit(CH_SP, 1'b1);       // whitespace-only text: the held space is flushed at the end
    push_unit(16'h0078, 1'b1);    // one-unit text
    push_unit(CH_LF, 1'b0);       // text opens with blank lines
    push_unit(CH_LF, 1'b0);
    push_unit(16'h0079, 1'b0);
    push_unit(CH_TAB, 1'b0);
    push_unit(16'h00A0, 1'b0);
    push_unit(16'h200A, 1'b0);
    push_unit(16'h2028, 1'b0);
    push_unit(16'h202F, 1'b0);
    push_unit(16'h205F, 1'b0);
    push_unit(16'h1680, 1'b0);
    push_unit(16'h007A, 1'b0);
    push_unit(16'h2029, 1'b1);
    wait_idle();

    // CR as plain whitespace, trimming, tabs left alone, one blank line kept.
    set_regs(8'd0, 8'd1, 8'd0, 8'd1);
    start_phase(0, 0);
    fill_random(20);
    wait_idle();

    // Sender idling. The phase ends inside a line at column 6 of 8.
    set_regs(8'd1, 8'd1, 8'd8, 8'd2);
    start_phase(52, 0);
    fill_random(20);
    repeat (6) push_unit(16'h0061, 1'b0);
    wait_idle();

    // Tab width changed mid-line: the held column is taken modulo 5.
    // Receiver stalls, with one long hold-off while the sender keeps going.
    set_regs(8'd1, 8'd0, 8'd5, 8'd20);
    start_phase(0, 52);
    hold_req++;
    push_unit(CH_TAB, 1'b0);
    push_unit(16'h0062, 1'b0);
    fill_random(20);
    wait_idle();

    // Out-of-range values: tab 31 acts as 16, blank limit 31 as 20; only
    // bit 0 of the line-end and trim bytes counts.
    set_regs(8'hFE, 8'hFE, 8'hFF, 8'hFF);
    start_phase(11, 11);
    fill_random(20);
    wait_idle();

    // Widest tabs with trimming; a write to an unused index changes nothing.
    // Last text overfills the held whitespace and sets the sticky flag.
    set_regs(8'd1, 8'd1, 8'd16, 8'd0);
    write_reg(CFG_UNUSED, 8'hFF);
    start_phase(52, 52);
    fill_random(20);
    push_unit(16'h0071, 1'b0);
    repeat (4) push_unit(CH_TAB, 1'b0);
    push_unit(16'h0072, 1'b1);
    wait_idle();

    if (fail_cnt == 0 && expect_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
